// File: sv/rpbc_pkg.sv
// Shared types and constants for the radio packet buffer controller.
package rpbc_pkg;

   // Buffer geometry
   localparam int BUF_DEPTH = 64;
   localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CNT_W     = 9;
   localparam int CRC_GOOD_POS = 7;   // bit 7 of link quality: CRC good

   // Transaction widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 24;

   // Command and event codes
   typedef enum logic [3:0] {
      FUNC_IDLE     = 4'd0,
      FUNC_START_RX = 4'd1,
      FUNC_START_TX = 4'd2,
      FUNC_WRITE    = 4'd3,
      FUNC_READ     = 4'd4,
      FUNC_BYTE     = 4'd5,
      FUNC_DONE     = 4'd6,
      FUNC_FAULT    = 4'd7,
      FUNC_SYNC     = 4'd8,
      FUNC_TICK     = 4'd9
   } func_type;

   // Link and radio modes
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RX   = 2'd1,
      MODE_TX   = 2'd2
   } mode_type;

endpackage

// File: sv/radio_packet_buffer_controller_top.sv
// Radio packet buffer controller: command decode, packet memory and result register.
//
//   channel | ports      | dir | tdata (low bit up)                      | tuser
//   --------+------------+-----+-----------------------------------------+------
//   request | req_t*     | in  | data_in[7:0] addr[15:8] link_qual[23:16] | func
//   result  | rsp_t*     | out | tx_byte, tx_byte_valid, read_data,      | -
//           |            |     | packet_received, tx_refused, need_tick, |
//           |            |     | tx_finished, link_state, zero pad       |
//
// One transaction per cycle sustained while results are taken. The accepting edge
// does the synchronous packet memory read into stage 1; stage 1 then loads the result
// register. Control state updates in the accept cycle, so the next request sees it
// at once. Synchronous reset clears control state; the packet memory is not cleared.
// A stalled result holds the result register; stage 1 still takes one more request,
// then req_tready drops until the result is taken.
module radio_packet_buffer_controller_top
   import rpbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] data_in, [15:8] addr, [23:16] link_quality
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [3:0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] tx_byte, [8] tx_byte_valid, [16:9] read_data, [17] packet_received,
   // [18] tx_refused, [19] need_tick, [20] tx_finished, [22:21] link_state,
   // [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Request fields
   func_type   func;
   logic [7:0] data_in;
   logic [7:0] addr;
   logic [7:0] link_quality;

   assign func         = func_type'(req_tuser);
   assign data_in      = req_tdata[7:0];
   assign addr         = req_tdata[15:8];
   assign link_quality = req_tdata[23:16];

   // Control state
   logic [CNT_W-1:0] byte_index_ff, byte_index_in;
   mode_type         link_mode_ff, link_mode_in;
   mode_type         radio_mode_ff, radio_mode_in;
   logic             rx_strobe_ff, rx_strobe_in;
   logic             done_ff, done_in;
   logic             fault_ff, fault_in;
   logic [7:0]       length_ff, length_in;   // shadow of packet entry 0

   // Packet memory
   logic [7:0]       mem [BUF_DEPTH];
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_wdata;
   logic [7:0]       rd_data_ff;

   // Pipeline: stage 1 waits on the memory read, stage 2 is the result register
   logic             s1_valid_ff;
   logic             s1_tx_valid_ff, s1_read_en_ff;
   logic             s1_got_ff, s1_refused_ff, s1_need_tick_ff, s1_tx_fin_ff;
   logic [1:0]       s1_link_ff;
   logic             out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic accept, s1_advance;

   // Handshake
   assign s1_advance = ~out_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s1_advance;
   assign accept     = req_tvalid & req_tready;

   // Shared conditions
   logic [CNT_W-1:0] stored_len;
   logic             idx_in_buf, addr_in_buf, tx_ok, rx_ok, start_ok;
   logic             got, refused, tx_valid, read_en, mem_write_cmd;

   always_comb begin
      stored_len  = CNT_W'({1'b0, length_ff}) + CNT_W'(1);
      idx_in_buf  = byte_index_ff < CNT_W'(BUF_DEPTH);
      addr_in_buf = {1'b0, addr} < CNT_W'(BUF_DEPTH);
      tx_ok       = (byte_index_ff < stored_len) && idx_in_buf;
      rx_ok       = ((byte_index_ff == '0) || (byte_index_ff < stored_len)) && idx_in_buf;
      start_ok    = (link_mode_ff == MODE_IDLE) ||
                    ((link_mode_ff == MODE_RX) && !rx_strobe_ff);
   end

   // Next state
   always_comb begin
      byte_index_in = byte_index_ff;
      link_mode_in  = link_mode_ff;
      radio_mode_in = radio_mode_ff;
      rx_strobe_in  = rx_strobe_ff;
      done_in       = done_ff;
      fault_in      = fault_ff;
      case (func)
         FUNC_IDLE: begin
            rx_strobe_in  = 1'b0;
            radio_mode_in = MODE_IDLE;
            link_mode_in  = MODE_IDLE;
            done_in       = 1'b0;
            fault_in      = 1'b0;
         end
         FUNC_START_RX: begin
            link_mode_in  = MODE_RX;
            radio_mode_in = MODE_RX;
            rx_strobe_in  = 1'b1;
            done_in       = 1'b0;
            fault_in      = 1'b0;
            byte_index_in = '0;
         end
         FUNC_START_TX: begin
            if (start_ok) begin
               link_mode_in  = MODE_TX;
               radio_mode_in = MODE_TX;
               rx_strobe_in  = 1'b0;
               done_in       = 1'b0;
               fault_in      = 1'b0;
               byte_index_in = '0;
            end
         end
         FUNC_BYTE: begin
            if (radio_mode_ff == MODE_TX) begin
               if (tx_ok) byte_index_in = byte_index_ff + CNT_W'(1);
               else       fault_in      = 1'b1;
            end else if (radio_mode_ff == MODE_RX) begin
               if (rx_ok)                             byte_index_in = byte_index_ff + CNT_W'(1);
               else if (byte_index_ff != stored_len) fault_in      = 1'b1;
            end
         end
         FUNC_DONE: begin
            if (byte_index_ff == stored_len) done_in  = 1'b1;
            else                             fault_in = 1'b1;
            rx_strobe_in  = 1'b0;
            radio_mode_in = MODE_IDLE;
            byte_index_in = '0;
         end
         FUNC_FAULT: begin
            rx_strobe_in  = 1'b0;
            radio_mode_in = MODE_IDLE;
            byte_index_in = '0;
            fault_in      = 1'b1;
         end
         FUNC_SYNC: begin
            byte_index_in = '0;
         end
         FUNC_TICK: begin
            // Packet complete or failed: back to idle, flags cleared
            if ((link_mode_ff == MODE_RX || link_mode_ff == MODE_TX) && (done_ff || fault_ff)) begin
               link_mode_in = MODE_IDLE;
               done_in      = 1'b0;
               fault_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Result flags and memory requests
   always_comb begin
      got           = 1'b0;
      refused       = 1'b0;
      tx_valid      = 1'b0;
      read_en       = 1'b0;
      mem_write_cmd = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = addr[IDX_W-1:0];
      mem_wdata     = data_in;
      mem_raddr     = addr[IDX_W-1:0];
      case (func)
         FUNC_START_TX: refused = ~start_ok;
         FUNC_WRITE: begin
            mem_write_cmd = addr_in_buf;
            mem_we        = accept & addr_in_buf;
         end
         FUNC_READ: read_en = addr_in_buf;
         FUNC_BYTE: begin
            mem_waddr = byte_index_ff[IDX_W-1:0];
            mem_raddr = byte_index_ff[IDX_W-1:0];
            if (radio_mode_ff == MODE_TX) tx_valid = tx_ok;
            else if (radio_mode_ff == MODE_RX) begin
               mem_write_cmd = rx_ok;
               mem_we        = accept & rx_ok;
            end
         end
         FUNC_TICK: got = (link_mode_ff == MODE_RX) && done_ff && link_quality[CRC_GOOD_POS];
         default: ;
      endcase
      mem_re = accept & (tx_valid | read_en);
   end

   // Entry 0 shadow follows every write to the length byte
   always_comb begin
      length_in = length_ff;
      if (mem_write_cmd && mem_waddr == '0) length_in = mem_wdata;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         link_mode_ff  <= MODE_IDLE;
         radio_mode_ff <= MODE_IDLE;
         rx_strobe_ff  <= 1'b0;
         done_ff       <= 1'b0;
         fault_ff      <= 1'b0;
         length_ff     <= '0;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         link_mode_ff  <= link_mode_in;
         radio_mode_ff <= radio_mode_in;
         rx_strobe_ff  <= rx_strobe_in;
         done_ff       <= done_in;
         fault_ff      <= fault_in;
         length_ff     <= length_in;
      end
   end

   // Packet memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tx_valid_ff  <= tx_valid;
         s1_read_en_ff   <= read_en;
         s1_got_ff       <= got;
         s1_refused_ff   <= refused;
         s1_need_tick_ff <= done_in;
         s1_tx_fin_ff    <= (link_mode_in != MODE_TX) | done_in | fault_in;
         s1_link_ff      <= link_mode_in;
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept)          s1_valid_ff <= 1'b1;
         else if (s1_advance) s1_valid_ff <= 1'b0;
         if (s1_advance)      out_valid_ff <= s1_valid_ff;
      end
   end

   // Result register, read data merged here
   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_data_ff <= {1'b0,
                         s1_link_ff,
                         s1_tx_fin_ff,
                         s1_need_tick_ff,
                         s1_refused_ff,
                         s1_got_ff,
                         (s1_read_en_ff ? rd_data_ff : 8'h00),
                         s1_tx_valid_ff,
                         (s1_tx_valid_ff ? rd_data_ff : 8'h00)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: sv/rpbc_checker.sv
// Port-level checks for the radio packet buffer controller, bound to the top level.
module rpbc_checker
   import rpbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // No transmit byte without its valid flag
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'h00)
      else $error("tx byte without valid");

   // Delivered packet always leaves the link idle
   a_got_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17] |-> rsp_tdata[22:21] == MODE_IDLE)
      else $error("packet received but link not idle");

   // Refusal only while busy; unfinished only while transmitting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[18] || rsp_tdata[22:21] != MODE_IDLE) &&
                     (rsp_tdata[20] || rsp_tdata[22:21] == MODE_TX))
      else $error("refusal or tx status inconsistent with link state");

endmodule

bind radio_packet_buffer_controller_top rpbc_checker u_rpbc_checker (.*);

// File: tb/sv/tb_radio_packet_buffer_controller_top.sv
// Self-checking stream testbench for the radio packet buffer controller top level.
module tb_radio_packet_buffer_controller_top
   import rpbc_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400_000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_EVERY  = 150;
   localparam int MAX_REPORTS  = 10;
   localparam int TAIL_CYCLES  = 10;

   // Result transaction, bit 0 at the bottom of the struct
   typedef struct packed {
      logic       pad;
      logic [1:0] link_state;
      logic       tx_finished;
      logic       need_tick;
      logic       tx_refused;
      logic       packet_received;
      logic [7:0] read_data;
      logic       tx_byte_valid;
      logic [7:0] tx_byte;
   } rsp_fields_type;

   // Predicts the controller and holds the results still owed by it
   class packet_buffer_scoreboard_type;
      logic [7:0]       store [BUF_DEPTH];
      bit               written [BUF_DEPTH];
      logic [CNT_W-1:0] byte_index;
      mode_type         link_mode;
      mode_type         radio_mode;
      bit               rx_strobe;
      bit               done_flag;
      bit               fault_flag;
      rsp_fields_type   expected_rsp_q [$];
      int               mismatches;
      int               results_seen;

      function new();
         foreach (store[i]) begin
            store[i]   = 8'h00;
            written[i] = 1'b0;
         end
         byte_index   = '0;
         link_mode    = MODE_IDLE;
         radio_mode   = MODE_IDLE;
         rx_strobe    = 1'b0;
         done_flag    = 1'b0;
         fault_flag   = 1'b0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      // Whole packet length: the length byte plus the bytes it counts
      function logic [CNT_W-1:0] packet_length();
         return {1'b0, store[0]} + 1'b1;
      endfunction

      function void enter_link_mode(mode_type mode);
         done_flag  = 1'b0;
         fault_flag = 1'b0;
         link_mode  = mode;
      endfunction

      function void radio_to_idle();
         rx_strobe  = 1'b0;
         radio_mode = MODE_IDLE;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      // Store entry that a request would read before anything wrote it, else -1
      function int unwritten_read(logic [3:0] code, logic [7:0] addr);
         if (!written[0] && (code == FUNC_BYTE || code == FUNC_DONE))
            return 0;
         if (code == FUNC_READ && addr < BUF_DEPTH && !written[addr])
            return int'(addr);
         if (code == FUNC_BYTE && radio_mode == MODE_TX &&
             byte_index < packet_length() && byte_index < BUF_DEPTH &&
             !written[byte_index])
            return int'(byte_index);
         return -1;
      endfunction

      // Apply one accepted request and queue the result it owes
      function void note_request(logic [3:0] code, logic [7:0] din, logic [7:0] addr,
                                 logic [7:0] quality);
         rsp_fields_type r;
         r = '0;
         case (code)
            FUNC_IDLE: begin
               radio_to_idle();
               enter_link_mode(MODE_IDLE);
            end
            FUNC_START_RX: begin
               link_mode  = MODE_RX;
               fault_flag = 1'b0;
               done_flag  = 1'b0;
               byte_index = '0;
               rx_strobe  = 1'b1;
               radio_mode = MODE_RX;
            end
            FUNC_START_TX: begin
               if (link_mode == MODE_IDLE || (link_mode == MODE_RX && !rx_strobe)) begin
                  enter_link_mode(MODE_TX);
                  byte_index = '0;
                  rx_strobe  = 1'b0;
                  radio_mode = MODE_TX;
               end else begin
                  r.tx_refused = 1'b1;
               end
            end
            FUNC_WRITE: begin
               if (addr < BUF_DEPTH) begin
                  store[addr]   = din;
                  written[addr] = 1'b1;
               end
            end
            FUNC_READ: begin
               if (addr < BUF_DEPTH) r.read_data = store[addr];
            end
            FUNC_BYTE: begin
               if (radio_mode == MODE_TX) begin
                  if (byte_index < packet_length() && byte_index < BUF_DEPTH) begin
                     r.tx_byte       = store[byte_index];
                     r.tx_byte_valid = 1'b1;
                     byte_index      = byte_index + 1'b1;
                  end else begin
                     fault_flag = 1'b1;
                  end
               end else if (radio_mode == MODE_RX) begin
                  // index zero carries the length byte itself
                  if ((byte_index == 0 || byte_index < packet_length()) &&
                      byte_index < BUF_DEPTH) begin
                     store[byte_index]   = din;
                     written[byte_index] = 1'b1;
                     byte_index          = byte_index + 1'b1;
                  end else if (byte_index != packet_length()) begin
                     fault_flag = 1'b1;
                  end
               end
            end
            FUNC_DONE: begin
               if (byte_index == packet_length()) done_flag = 1'b1;
               else fault_flag = 1'b1;
               radio_to_idle();
               byte_index = '0;
            end
            FUNC_FAULT: begin
               radio_to_idle();
               byte_index = '0;
               fault_flag = 1'b1;
            end
            FUNC_SYNC: begin
               byte_index = '0;
            end
            FUNC_TICK: begin
               if (link_mode == MODE_RX) begin
                  if (done_flag) begin
                     if (quality[CRC_GOOD_POS]) r.packet_received = 1'b1;
                     enter_link_mode(MODE_IDLE);
                  end
                  if (fault_flag) enter_link_mode(MODE_IDLE);
               end else if (link_mode == MODE_TX) begin
                  if (done_flag || fault_flag) enter_link_mode(MODE_IDLE);
               end
            end
            default: ;
         endcase
         r.need_tick   = done_flag;
         r.tx_finished = (link_mode != MODE_TX) || done_flag || fault_flag;
         r.link_state  = link_mode;
         expected_rsp_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [RSP_DATA_W-1:0] want,
                                  logic [RSP_DATA_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
         end
      endfunction

      // Compare one accepted result against the oldest expectation
      function void check_result(logic [RSP_DATA_W-1:0] word);
         rsp_fields_type got;
         rsp_fields_type want;
         got = word;
         results_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with none outstanding: %h", results_seen, word);
            return;
         end
         want = expected_rsp_q.pop_front();
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("tx_byte_valid", want.tx_byte_valid, got.tx_byte_valid);
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("packet_received", want.packet_received, got.packet_received);
         compare_field("tx_refused", want.tx_refused, got.tx_refused);
         compare_field("need_tick", want.need_tick, got.need_tick);
         compare_field("tx_finished", want.tx_finished, got.tx_finished);
         compare_field("link_state", want.link_state, got.link_state);
         compare_field("pad", want.pad, got.pad);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [7:0] data_in, [15:8] addr, [23:16] link_quality
   logic [REQ_USER_W-1:0] req_tuser = '0;    // [3:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // tx_byte .. link_state, pad, low bit up

   packet_buffer_scoreboard_type sb = new();

   int send_run  = 0;
   int rsp_run   = 0;
   int rsp_hold  = 0;
   int items_sent = 0;
   int cycle_count = 0;

   radio_packet_buffer_controller_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Random wait before the next transaction, with bursts of no waiting
   function automatic int draw_wait(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Result side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            rsp_hold = draw_wait(rsp_run);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // One request transaction, held until accepted
   task automatic drive_transaction(logic [3:0] code, logic [7:0] din, logic [7:0] addr,
                                    logic [7:0] quality);
      int gap;
      gap = draw_wait(send_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {quality, addr, din};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(code, din, addr, quality);
      items_sent++;
   endtask

   // Fill any store entry the request would read before it is written
   task automatic send_command(logic [3:0] code, logic [7:0] din, logic [7:0] addr,
                               logic [7:0] quality);
      int idx;
      idx = sb.unwritten_read(code, addr);
      while (idx >= 0) begin
         drive_transaction(FUNC_WRITE, 8'($urandom), 8'(idx), 8'($urandom));
         idx = sb.unwritten_read(code, addr);
      end
      drive_transaction(code, din, addr, quality);
   endtask

   task automatic noise(int count);
      for (int i = 0; i < count; i++)
         send_command(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 11) == 0) noise(1);
   endtask

   task automatic event_only(logic [3:0] code);
      send_command(code, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Hold off until every owed result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Load a packet and stream it out; sometimes longer than the buffer
   task automatic tx_packet();
      int len;
      int count;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 10);
      send_command(FUNC_WRITE, 8'(len), 8'd0, 8'($urandom));
      if (len < BUF_DEPTH) begin
         for (int i = 1; i <= len; i++)
            if ($urandom_range(0, 3) != 0)
               send_command(FUNC_WRITE, 8'($urandom), 8'(i), 8'($urandom));
         count = len + 1 + $urandom_range(0, 2) - (($urandom_range(0, 5) == 0) ? 1 : 0);
      end else begin
         count = BUF_DEPTH + $urandom_range(1, 2);
      end
      maybe_noise();
      event_only(FUNC_START_TX);
      if ($urandom_range(0, 7) == 0) event_only(FUNC_START_TX);
      for (int i = 0; i < count; i++) begin
         event_only(FUNC_BYTE);
         maybe_noise();
      end
      if ($urandom_range(0, 7) == 0) event_only(FUNC_FAULT);
      else event_only(FUNC_DONE);
      if ($urandom_range(0, 1) == 0)
         send_command(FUNC_READ, 8'($urandom), 8'($urandom_range(0, BUF_DEPTH - 1)),
                      8'($urandom));
      event_only(FUNC_TICK);
   endtask

   // Receive a packet with random content; sometimes short, long or past the buffer
   task automatic rx_packet();
      int len;
      int count;
      logic [7:0] quality;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 10);
      if (len < BUF_DEPTH)
         count = len + 1 + $urandom_range(0, 2) - (($urandom_range(0, 5) == 0) ? 1 : 0);
      else
         count = BUF_DEPTH + $urandom_range(0, 3);
      event_only(FUNC_START_RX);
      if ($urandom_range(0, 3) == 0) event_only(FUNC_START_TX);
      if ($urandom_range(0, 5) == 0) event_only(FUNC_SYNC);
      for (int i = 0; i < count; i++) begin
         send_command(FUNC_BYTE, (i == 0) ? 8'(len) : 8'($urandom), 8'($urandom),
                      8'($urandom));
         maybe_noise();
      end
      if ($urandom_range(0, 7) == 0) event_only(FUNC_FAULT);
      else event_only(FUNC_DONE);
      if ($urandom_range(0, 1) == 0)
         send_command(FUNC_READ, 8'($urandom), 8'($urandom_range(0, BUF_DEPTH - 1)),
                      8'($urandom));
      if ($urandom_range(0, 5) == 0) event_only(FUNC_START_TX);
      quality = 8'($urandom);
      quality[CRC_GOOD_POS] = ($urandom_range(0, 3) != 0);
      send_command(FUNC_TICK, 8'($urandom), 8'($urandom), quality);
   endtask

   // Stimulus
   initial begin
      int random_end;
      int next_drain;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: buffer access at the extremes
      send_command(FUNC_WRITE, 8'd2, 8'd0, 8'h00);
      send_command(FUNC_WRITE, 8'hFF, 8'd1, 8'hFF);
      send_command(FUNC_WRITE, 8'h00, 8'd2, 8'h00);
      send_command(FUNC_WRITE, 8'h5A, 8'hFF, 8'hFF);   // out of range, ignored
      send_command(FUNC_READ, 8'h00, 8'd0, 8'h00);
      send_command(FUNC_READ, 8'h00, 8'd2, 8'h00);
      send_command(FUNC_READ, 8'hFF, 8'd200, 8'h00);   // out of range reads zero

      // Transmit refused under an active receive strobe, accepted after done
      send_command(FUNC_START_RX, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_START_TX, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_DONE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_START_TX, 8'h00, 8'h00, 8'h00);

      // Whole packet out, then a request past the length
      send_command(FUNC_BYTE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_BYTE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_BYTE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_BYTE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_TICK, 8'h00, 8'h00, 8'h00);

      // Receive with one excess byte at exactly the length, CRC-good tick
      send_command(FUNC_START_RX, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_BYTE, 8'd1, 8'h00, 8'h00);
      send_command(FUNC_BYTE, 8'hFF, 8'hFF, 8'hFF);
      send_command(FUNC_BYTE, 8'h80, 8'h00, 8'h00);
      send_command(FUNC_DONE, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_TICK, 8'h00, 8'h00, 8'hFF);

      // Remaining events and unused codes
      send_command(FUNC_SYNC, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_FAULT, 8'h00, 8'h00, 8'h00);
      send_command(FUNC_IDLE, 8'h00, 8'h00, 8'h00);
      send_command(4'd10, 8'hFF, 8'hFF, 8'hFF);
      send_command(4'd15, 8'h00, 8'h00, 8'h00);
      drain();

      // Random packets with noise and broken sequences
      random_end = items_sent + RANDOM_ITEMS;
      next_drain = items_sent + DRAIN_EVERY;
      while (items_sent < random_end) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: tx_packet();
            4, 5, 6, 7: rx_packet();
            default:    noise($urandom_range(1, 4));
         endcase
         if (items_sent >= next_drain) begin
            drain();
            next_drain = items_sent + DRAIN_EVERY;
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
